// ===== rtl/core/bfiq_pkg.sv =====
`timescale 1ns / 1ps
package bfiq_pkg;

  localparam logic [31:0] MmC1      = 32'hcc9e2d51;
  localparam logic [31:0] MmC2      = 32'h1b873593;
  localparam logic [31:0] MmAdd     = 32'he6546b64;
  localparam logic [31:0] MmF1      = 32'h85ebca6b;
  localparam logic [31:0] MmF2      = 32'hc2b2ae35;
  localparam logic [31:0] FnvBasis  = 32'h811c9dc5;
  localparam logic [31:0] FnvPrime  = 32'h01000193;
  localparam int unsigned MmRotK    = 15;
  localparam int unsigned MmRotH    = 13;

  localparam int unsigned FbW       = 17;
  localparam int unsigned HcW       = 9;
  localparam logic [FbW-1:0] FbReset = 17'd65536;
  localparam logic [HcW-1:0] HcReset = 9'd7;

  // register indexes
  localparam logic RegFilterBits = 1'b0;
  localparam logic RegHashCount  = 1'b1;

  typedef enum logic [4:0] {
    OP_CLEAR,
    OP_IDLE,
    OP_ABSORB,
    OP_MIX1,
    OP_MIX2,
    OP_MIX3,
    OP_FIN0,
    OP_FT1,
    OP_FT2,
    OP_FIN2,
    OP_FIN3,
    OP_FIN4,
    OP_DIVSET,
    OP_DIV,
    OP_PROBE,
    OP_CHECK,
    OP_DONE
  } op_e;

  typedef struct packed {
    op_e  op;
    logic take;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic byte_ok;
    logic blk_full;
    logic last;
    logic tail_nz;
    logic no_probes;
    logic div_last;
    logic last_probe;
    logic probe_end;
    logic is_query;
    logic out_free;
  } dp_sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

endpackage

// ===== rtl/core/bfiq_ctrl.sv =====
`timescale 1ns / 1ps
module bfiq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  bfiq_pkg::dp_sts_t sts_i,
  output bfiq_pkg::dp_cmd_t cmd_o,
  output logic             in_ready_o
);
  import bfiq_pkg::*;

  op_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= OP_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = state_q;
    cmd_o.take = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      OP_CLEAR: begin
        if (sts_i.clr_done) state_d = OP_IDLE;
      end
      OP_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = OP_ABSORB;
        end
      end
      OP_ABSORB: begin
        if (sts_i.byte_ok && sts_i.blk_full) state_d = OP_MIX1;
        else if (sts_i.last)                 state_d = OP_FIN0;
        else                                 state_d = OP_IDLE;
      end
      OP_MIX1: state_d = OP_MIX2;
      OP_MIX2: state_d = OP_MIX3;
      OP_MIX3: state_d = sts_i.last ? OP_FIN0 : OP_IDLE;
      OP_FIN0: state_d = sts_i.tail_nz ? OP_FT1 : OP_FIN2;
      OP_FT1:  state_d = OP_FT2;
      OP_FT2:  state_d = OP_FIN2;
      OP_FIN2: state_d = OP_FIN3;
      OP_FIN3: state_d = OP_FIN4;
      OP_FIN4: state_d = sts_i.no_probes ? OP_DONE : OP_DIVSET;
      OP_DIVSET: state_d = OP_DIV;
      OP_DIV: begin
        if (sts_i.div_last) state_d = OP_PROBE;
      end
      OP_PROBE: begin
        if (sts_i.is_query)        state_d = OP_CHECK;
        else if (sts_i.last_probe) state_d = OP_DONE;
        else                       state_d = OP_DIVSET;
      end
      OP_CHECK: state_d = sts_i.probe_end ? OP_DONE : OP_DIVSET;
      OP_DONE: begin
        if (sts_i.out_free) state_d = OP_IDLE;
      end
      default: state_d = OP_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/bfiq_dp.sv =====
`timescale 1ns / 1ps
module bfiq_dp #(
  parameter int unsigned MAX_FILTER_BITS = 65536,
  parameter int unsigned MAX_PROBES      = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bfiq_pkg::dp_cmd_t           cmd_i,
  output bfiq_pkg::dp_sts_t           sts_o,
  input  logic                        command_i,
  input  logic [7:0]                  key_byte_i,
  input  logic                        byte_valid_i,
  input  logic                        last_byte_i,
  input  logic [bfiq_pkg::FbW-1:0]    filter_bits_i,
  input  logic [bfiq_pkg::HcW-1:0]    hash_count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        is_member_o,
  output logic                        was_query_o,
  output logic [31:0]                 items_inserted_o
);
  import bfiq_pkg::*;

  localparam int unsigned MW = $clog2(MAX_FILTER_BITS + 1);
  localparam int unsigned AW = $clog2(MAX_FILTER_BITS);
  localparam int unsigned PW = $clog2(MAX_PROBES + 1);

  // key beat latched at acceptance
  logic [7:0]  b_q;
  logic        bv_q, last_q, cmd_q;
  // hash state
  logic [31:0] mur_q, fnv_q, len_q, k_q, h_q, h2_q, x_q, sx_q;
  logic [23:0] part_q;
  // probe loop
  logic [MW-1:0] m_q, rem_q;
  logic [PW-1:0] kc_q, i_q;
  logic [4:0]    dcnt_q;
  logic          member_q, rd_q;
  logic [AW-1:0] clr_q;
  logic [31:0]   cnt_q;
  logic          out_valid_q;

  logic          mem_q [MAX_FILTER_BITS];

  logic [MW:0]   trial;
  logic [MW:0]   rem_nx;
  logic [MW-1:0] m_sat;
  logic [PW-1:0] k_sat;
  logic [1:0]    pos;
  logic          out_free;
  logic          out_load;
  logic          mem_we, mem_wd;
  logic [AW-1:0] mem_wa;

  assign pos      = len_q[1:0];
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (cmd_i.op == OP_DONE) && out_free;

  always_comb begin
    if (filter_bits_i == '0) begin
      m_sat = MW'(1);
    end else if (32'(filter_bits_i) > 32'(MAX_FILTER_BITS)) begin
      m_sat = MW'(MAX_FILTER_BITS);
    end else begin
      m_sat = MW'(filter_bits_i);
    end
    if (32'(hash_count_i) > 32'(MAX_PROBES)) begin
      k_sat = PW'(MAX_PROBES);
    end else begin
      k_sat = PW'(hash_count_i);
    end
  end

  // restoring remainder, one dividend bit a cycle
  assign trial  = {rem_q, sx_q[31]};
  assign rem_nx = (trial >= {1'b0, m_q}) ? (trial - {1'b0, m_q}) : trial;

  always_comb begin
    sts_o.clr_done   = (clr_q == AW'(MAX_FILTER_BITS - 1));
    sts_o.byte_ok    = bv_q;
    sts_o.blk_full   = (pos == 2'd3);
    sts_o.last       = last_q;
    sts_o.tail_nz    = (pos != 2'd0);
    sts_o.no_probes  = (k_sat == '0);
    sts_o.div_last   = (dcnt_q == 5'd31);
    sts_o.last_probe = (i_q + PW'(1) == kc_q);
    sts_o.probe_end  = (i_q == kc_q);
    sts_o.is_query   = cmd_q;
    sts_o.out_free   = out_free;
  end

  // bit store: one write port, one registered read port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = rem_q[AW-1:0];
    mem_wd = 1'b1;
    if (cmd_i.op == OP_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = 1'b0;
    end else if (cmd_i.op == OP_PROBE && !cmd_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (cmd_i.op == OP_PROBE) rd_q <= mem_q[rem_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      mur_q       <= '0;
      fnv_q       <= FnvBasis;
      part_q      <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result overrides the drain of the old one
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_CLEAR: clr_q <= clr_q + AW'(1);
        OP_ABSORB: begin
          if (bv_q) begin
            fnv_q <= (fnv_q ^ {24'd0, b_q}) * FnvPrime;
            len_q <= len_q + 32'd1;
            case (pos)
              2'd0: part_q[7:0]   <= b_q;
              2'd1: part_q[15:8]  <= b_q;
              2'd2: part_q[23:16] <= b_q;
              default: part_q     <= '0;
            endcase
          end
        end
        OP_MIX3: mur_q <= rotl(mur_q ^ k_q, MmRotH) * 32'd5 + MmAdd;
        OP_FIN4: begin
          mur_q  <= '0;
          fnv_q  <= FnvBasis;
          part_q <= '0;
          len_q  <= '0;
        end
        OP_DONE: begin
          if (out_free && !cmd_q) cnt_q <= cnt_q + 32'd1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      b_q    <= key_byte_i;
      bv_q   <= byte_valid_i;
      last_q <= last_byte_i;
      cmd_q  <= command_i;
    end
    case (cmd_i.op)
      OP_ABSORB: k_q <= {b_q, part_q};
      OP_MIX1:   k_q <= k_q * MmC1;
      OP_MIX2:   k_q <= rotl(k_q, MmRotK) * MmC2;
      OP_FIN0: begin
        k_q <= {8'd0, part_q} * MmC1;
        h_q <= mur_q ^ len_q;
      end
      OP_FT1:    k_q <= rotl(k_q, MmRotK) * MmC2;
      OP_FT2:    h_q <= mur_q ^ k_q ^ len_q;
      OP_FIN2:   h_q <= (h_q ^ (h_q >> 16)) * MmF1;
      OP_FIN3:   h_q <= (h_q ^ (h_q >> 13)) * MmF2;
      OP_FIN4: begin
        x_q      <= h_q ^ (h_q >> 16);
        h2_q     <= fnv_q;
        m_q      <= m_sat;
        kc_q     <= k_sat;
        i_q      <= '0;
        member_q <= 1'b1;
      end
      OP_DIVSET: begin
        rem_q  <= '0;
        sx_q   <= x_q;
        dcnt_q <= '0;
      end
      OP_DIV: begin
        rem_q  <= rem_nx[MW-1:0];
        sx_q   <= {sx_q[30:0], 1'b0};
        dcnt_q <= dcnt_q + 5'd1;
      end
      OP_PROBE: begin
        x_q <= x_q + h2_q;
        i_q <= i_q + PW'(1);
      end
      OP_CHECK: member_q <= member_q & rd_q;
      OP_DONE: begin
        if (out_free) begin
          is_member_o      <= cmd_q & member_q;
          was_query_o      <= cmd_q;
          items_inserted_o <= cmd_q ? cnt_q : cnt_q + 32'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/bloom_filter_insert_query.sv =====
`timescale 1ns / 1ps
// Channel | Handshake                 | Payload
// in      | in_valid_i / in_ready_o   | command_i, key_byte_i, byte_valid_i, last_byte_i
// out     | out_valid_o / out_ready_i | is_member_o, was_query_o, items_inserted_o
// cfg     | APB psel/penable/pwrite   | paddr, pwdata, prdata (0: filter_bits, 4: hash_count)
//
// A key byte beat passes the idle and absorb states, and the three mix states
// when it completes a 4-byte Murmur block (three registered multiplies on one
// chain). A key end runs the finalisation states (the two tail states skipped
// with no tail bytes), then per probe the one-bit-a-cycle remainder unit and a
// probe state, plus a check state for a query, then the done state loads the
// output register, where the result waits. After reset a clearing pass sweeps
// the bit store with in_ready_o low. A stall on the output holds the block at the key end.
module bloom_filter_insert_query #(
  parameter int unsigned MAX_FILTER_BITS = 65536,
  parameter int unsigned MAX_PROBES      = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  key_byte_i,
  input  logic        byte_valid_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_member_o,
  output logic        was_query_o,
  output logic [31:0] items_inserted_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bfiq_pkg::*;

  logic [FbW-1:0] fb_q;
  logic [HcW-1:0] hc_q;
  logic           reg_idx;
  dp_cmd_t        cmd;
  dp_sts_t        sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  // config registers, written on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q <= FbReset;
      hc_q <= HcReset;
    end else if (psel && penable && pwrite) begin
      if (reg_idx == RegFilterBits) fb_q <= pwdata[FbW-1:0];
      else                          hc_q <= pwdata[HcW-1:0];
    end
  end

  always_comb begin
    if (reg_idx == RegFilterBits) prdata = {{(32-FbW){1'b0}}, fb_q};
    else                          prdata = {{(32-HcW){1'b0}}, hc_q};
  end

  // sequencer: one state per hashing / probing step
  bfiq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  // hash units, remainder unit, bit store and output register
  bfiq_dp #(
    .MAX_FILTER_BITS (MAX_FILTER_BITS),
    .MAX_PROBES      (MAX_PROBES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .command_i        (command_i),
    .key_byte_i       (key_byte_i),
    .byte_valid_i     (byte_valid_i),
    .last_byte_i      (last_byte_i),
    .filter_bits_i    (fb_q),
    .hash_count_i     (hc_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .is_member_o      (is_member_o),
    .was_query_o      (was_query_o),
    .items_inserted_o (items_inserted_o)
  );

endmodule

// ===== dv/tb_bloom_filter_insert_query.sv =====
`timescale 1ns / 1ps
// Bloom filter testbench: keys are fed as byte beats, a local hash and bit
// store predicts each key-end result, and the monitor checks results in order.
module tb_bloom_filter_insert_query;
  import bfiq_pkg::*;

  localparam int unsigned StoreBits = 65536;
  localparam int unsigned MaxProbes = 256;
  localparam int unsigned CycleLimit = 3000000;

  typedef struct {
    logic       cmd;
    logic [7:0] kb;
    logic       bv;
    logic       lb;
  } key_beat_t;

  typedef struct {
    logic        member;
    logic        query;
    logic [31:0] count;
  } bloom_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic command_i = 1'b0;
  logic [7:0] key_byte_i = '0;
  logic byte_valid_i = 1'b0;
  logic last_byte_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic is_member_o;
  logic was_query_o;
  logic [31:0] items_inserted_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bloom_filter_insert_query dut (.*);

  // testbench control
  key_beat_t  beat_q[$];
  bloom_res_t result_q[$];
  int         mismatches = 0;
  bit         quiet = 1'b0;     // no idling in the last part of the run
  bit         hold_req = 1'b0;  // ask the monitor for one long hold-off
  int         known_ids[$];
  int         next_id = 1;

  // predictor state
  bit          store_bits[StoreBits];
  logic [31:0] mm_acc, fnv_acc, tail_blk, key_len, ins_count;
  logic [16:0] fb_reg;
  logic [8:0]  hc_reg;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rol32(logic [31:0] x, int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] mm_scramble(logic [31:0] k);
    logic [31:0] t;
    t = k * 32'hcc9e2d51;
    t = rol32(t, 15);
    return t * 32'h1b873593;
  endfunction

  task automatic hash_reset();
    mm_acc = '0;
    fnv_acc = 32'h811c9dc5;
    tail_blk = '0;
    key_len = '0;
  endtask

  // advance the hash by one accepted beat; push a result at key end
  task automatic predict_beat(key_beat_t b);
    logic [31:0] h1, h2, m, k, idx;
    logic        member;
    bloom_res_t  r;
    if (b.bv) begin
      fnv_acc = (fnv_acc ^ {24'd0, b.kb}) * 32'h01000193;
      if (key_len[1:0] == 2'd3) begin
        mm_acc ^= mm_scramble(tail_blk | ({24'd0, b.kb} << 24));
        mm_acc = rol32(mm_acc, 13) * 32'd5 + 32'he6546b64;
        tail_blk = '0;
      end else begin
        tail_blk |= {24'd0, b.kb} << (8 * key_len[1:0]);
      end
      key_len += 1;
    end
    if (!b.lb) return;
    h1 = mm_acc;
    if (key_len[1:0] != 2'd0) h1 ^= mm_scramble(tail_blk);
    h1 ^= key_len;
    h1 ^= h1 >> 16;
    h1 *= 32'h85ebca6b;
    h1 ^= h1 >> 13;
    h1 *= 32'hc2b2ae35;
    h1 ^= h1 >> 16;
    h2 = fnv_acc;
    m = {15'd0, fb_reg};
    if (m == 0) m = 1;
    if (m > StoreBits) m = StoreBits;
    k = {23'd0, hc_reg};
    if (k > MaxProbes) k = MaxProbes;
    member = 1'b1;
    for (int unsigned i = 0; i < k; i++) begin
      idx = (h1 + i * h2) % m;
      if (!b.cmd) store_bits[idx] = 1'b1;
      else if (!store_bits[idx]) member = 1'b0;
    end
    if (!b.cmd) begin
      ins_count += 1;
      member = 1'b0;
    end
    r.member = member;
    r.query = b.cmd;
    r.count = ins_count;
    result_q.push_back(r);
    hash_reset();
  endtask

  // driver: at most one nonblocking write of valid per edge
  int gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    key_beat_t nxt;
    bit        busy;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        nxt.cmd = command_i;
        nxt.kb = key_byte_i;
        nxt.bv = byte_valid_i;
        nxt.lb = last_byte_i;
        predict_beat(nxt);
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap > 0) begin
          gap--;
          in_valid_i <= 1'b0;
        end else if (beat_q.size() > 0) begin
          nxt = beat_q.pop_front();
          command_i <= nxt.cmd;
          key_byte_i <= nxt.kb;
          byte_valid_i <= nxt.bv;
          last_byte_i <= nxt.lb;
          in_valid_i <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 3);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure plus one long hold-off on request
  int  stall = 0;
  int  hold_cnt = 0;
  bit  hold_used = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    bloom_res_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result member=%0b query=%0b count=%0d",
                   $time, is_member_o, was_query_o, items_inserted_o);
          mismatches++;
        end else begin
          e = result_q.pop_front();
          if (is_member_o !== e.member) begin
            $display("%0t: is_member expected %0b actual %0b", $time, e.member, is_member_o);
            mismatches++;
          end
          if (was_query_o !== e.query) begin
            $display("%0t: was_query expected %0b actual %0b", $time, e.query, was_query_o);
            mismatches++;
          end
          if (items_inserted_o !== e.count) begin
            $display("%0t: items_inserted expected %0d actual %0d",
                     $time, e.count, items_inserted_o);
            mismatches++;
          end
        end
      end
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_cnt = 3000;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) stall = $urandom_range(1, 3);
      end
    end
  end

  // run limit
  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_beat(logic cmd, logic [7:0] kb, logic bv, logic lb);
    key_beat_t b;
    b.cmd = cmd;
    b.kb = kb;
    b.bv = bv;
    b.lb = lb;
    beat_q.push_back(b);
  endtask

  function automatic logic [7:0] key_byte_of(int id, int j);
    logic [31:0] v;
    v = id * 32'd2654435761 + j * 32'd40503;
    return v[23:16] ^ v[7:0];
  endfunction

  // one key: optional invalid noise beats between bytes, end on byte or on
  // a separate invalid beat
  task automatic push_key(logic cmd, int id, int len, bit noisy);
    bit end_on_byte;
    end_on_byte = (len > 0) && $urandom_range(0, 1);
    for (int j = 0; j < len; j++) begin
      if (noisy && $urandom_range(0, 3) == 0)
        push_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, 1'b0);
      push_beat(end_on_byte && j == len - 1 ? cmd : 1'($urandom_range(0, 1)),
                key_byte_of(id, j), 1'b1, end_on_byte && j == len - 1);
    end
    if (!end_on_byte) push_beat(cmd, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic apb_write(logic idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == RegFilterBits) fb_reg = val[16:0];
    else hc_reg = val[8:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (beat_q.size() > 0 || in_valid_i || result_q.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic random_keys(int n);
    int start, id, len;
    start = 0;
    while (start < n) begin
      start = start + 1;
      if ($urandom_range(0, 9) == 0) begin
        push_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, 1'b0);
        continue;
      end
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 7);
      if ($urandom_range(0, 1) == 0) begin
        id = next_id++;
        known_ids.push_back(id);
        push_key(1'b0, id, len, 1'b1);
      end else begin
        if (known_ids.size() > 0 && $urandom_range(0, 9) < 7)
          id = known_ids[$urandom_range(0, known_ids.size() - 1)];
        else
          id = next_id++;
        push_key(1'b1, id, len, 1'b1);
      end
      start = start + len;
    end
  endtask

  initial begin
    for (int i = 0; i < StoreBits; i++) store_bits[i] = 1'b0;
    hash_reset();
    ins_count = '0;
    fb_reg = 17'd65536;
    hc_reg = 9'd7;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset settings: empty keys, byte extremes, noise, re-query
    push_beat(1'b1, 8'h00, 1'b0, 1'b1);            // empty key query
    push_beat(1'b0, 8'hff, 1'b0, 1'b1);            // empty key insert
    push_beat(1'b1, 8'h5a, 1'b0, 1'b1);            // now a member
    push_beat(1'b1, 8'hff, 1'b0, 1'b0);            // lone noise beat
    push_beat(1'b0, 8'h00, 1'b1, 1'b1);
    push_beat(1'b0, 8'hff, 1'b1, 1'b1);
    push_beat(1'b1, 8'hff, 1'b1, 1'b1);
    push_key(1'b0, 900, 4, 1'b1);
    push_key(1'b1, 900, 4, 1'b0);
    push_key(1'b0, 901, 7, 1'b0);
    push_key(1'b1, 901, 7, 1'b1);
    push_key(1'b1, 902, 5, 1'b0);
    drain();

    // single-bit filter, one probe: everything collides
    apb_write(RegFilterBits, 32'd1);
    apb_write(RegHashCount, 32'd1);
    push_key(1'b1, 903, 3, 1'b0);
    push_key(1'b0, 904, 2, 1'b0);
    push_key(1'b1, 905, 6, 1'b0);
    drain();

    // zero modulus and no probes
    apb_write(RegFilterBits, 32'd0);
    apb_write(RegHashCount, 32'd0);
    push_key(1'b1, 906, 1, 1'b0);
    push_key(1'b0, 907, 2, 1'b0);
    drain();

    // oversize modulus and probe count, both saturate
    apb_write(RegFilterBits, 32'h1ffff);
    apb_write(RegHashCount, 32'h1ff);
    push_key(1'b0, 908, 3, 1'b0);
    push_key(1'b1, 908, 3, 1'b0);
    push_key(1'b1, 909, 2, 1'b0);
    drain();

    apb_write(RegFilterBits, 32'd65536);
    apb_write(RegHashCount, 32'd256);
    push_key(1'b1, 910, 4, 1'b0);
    drain();

    // random phases, mostly small probe counts to keep the run short
    for (int ph = 0; ph < 6; ph++) begin
      apb_write(RegFilterBits, $urandom_range(8, 3000));
      apb_write(RegHashCount, $urandom_range(1, 8));
      if (ph == 1) hold_req = 1'b1;
      if (ph == 5) quiet = 1'b1;
      random_keys(210);
      drain();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bfiq_pkg.sv
rtl/core/bfiq_ctrl.sv
rtl/core/bfiq_dp.sv
rtl/core/bloom_filter_insert_query.sv
dv/tb_bloom_filter_insert_query.sv
